/* hdl/ppts_pkg.sv */
// Shared types, codes and reset presets for the periodic poll table scheduler.
// Used by ppts_table and periodic_poll_table_scheduler; no dependencies.
package ppts_pkg;

  localparam int SLOTS         = 16;
  localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PRESET_COUNT  = 8;
  localparam int RES_SLOT_W    = 4;
  localparam int IN_DATA_W     = 112;
  localparam int OUT_DATA_W    = 24;

  typedef logic [SLOT_W-1:0] idx_t;

  // operation codes on the input tuser
  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_DUE      = 3'd0,
    ST_NONE     = 3'd1,
    ST_ADDED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  // one table entry
  typedef struct packed {
    logic        enabled;
    logic [7:0]  mode;
    logic [7:0]  id;
    logic [31:0] period;
    logic [63:0] last_time;
  } slot_t;

  // one result word, without the last flag
  typedef struct packed {
    logic [RES_SLOT_W-1:0] slot;
    logic [7:0]            id;
    logic [7:0]            mode;
    status_t               status;
  } res_t;

  // table write request
  typedef struct packed {
    logic  en;
    idx_t  idx;
    slot_t entry;
  } tbl_wr_t;

  function automatic logic [7:0] preset_id(input int i);
    logic [7:0] v;
    case (i)
      0:       v = 8'h0C;
      1:       v = 8'h0D;
      2:       v = 8'h11;
      3:       v = 8'h04;
      4:       v = 8'h05;
      5:       v = 8'h0F;
      6:       v = 8'h2F;
      7:       v = 8'h46;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] preset_period(input int i);
    logic [31:0] v;
    case (i)
      0, 1, 2: v = 32'd100000;
      3:       v = 32'd500000;
      4, 5:    v = 32'd1000000;
      6, 7:    v = 32'd5000000;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic slot_t preset_entry(input int i);
    slot_t e;
    e.enabled   = (i < PRESET_COUNT);
    e.mode      = (i < PRESET_COUNT) ? 8'h01 : 8'h00;
    e.id        = preset_id(i);
    e.period    = preset_period(i);
    e.last_time = 64'd0;
    return e;
  endfunction

endpackage

/* hdl/periodic_poll_table_scheduler.sv */
// Periodic poll table scheduler: top level with the scan sequencer and output register.
// Depends on ppts_pkg and ppts_table.
//
// Each input word (tuser = op) is handled by a sequencer that walks the slot table
// one entry per cycle through a single 64-bit subtract/compare unit; a poll stalls on
// a due entry while the previous due word still waits on a busy output. A poll scans
// all SLOTS entries and then delivers the final word; out_tready can hold off both.
// Add and remove stop at the first hit, or scan all SLOTS entries when nothing
// matches. Due results are emitted one behind the scan so the last one can carry
// tlast. in_tready is low while an item is in work; op 3 is dropped with no result.
module periodic_poll_table_scheduler import ppts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] now_us, [71:64] req_mode, [79:72] req_id, [111:80] period_us
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [10:3] due_mode, [18:11] due_id, [22:19] slot, [23] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  state_t      state_r, state_nxt;
  idx_t        idx_r, idx_nxt;
  logic [1:0]  op_r;
  logic [63:0] now_r;
  logic [7:0]  mode_r, id_r;
  logic [31:0] period_r;
  res_t        held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic        out_valid_r;
  res_t        out_res_r;
  logic        out_last_r;

  slot_t       ent;
  tbl_wr_t     wr;
  logic        in_acc, out_free, push, push_last;
  logic [63:0] diff;
  logic        due, is_end, match;
  res_t        res_mid;

  ppts_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_entry (ent),
    .wr       (wr)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // shared compare unit: wrapping elapsed time against the interval
  assign diff   = now_r - ent.last_time;
  assign due    = ent.enabled && (diff >= {32'd0, ent.period});
  assign match  = ent.enabled && (ent.mode == mode_r) && (ent.id == id_r);
  assign is_end = (idx_r == idx_t'(SLOTS - 1));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    push       = 1'b0;
    push_last  = 1'b0;
    res_mid    = held_r;
    wr.en      = 1'b0;
    wr.idx     = idx_r;
    wr.entry   = ent;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt    = '0;
          held_v_nxt = 1'b0;
          if (in_tuser inside {OP_POLL, OP_ADD, OP_REMOVE}) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        case (op_r)
          OP_POLL: begin
            if (!(due && held_v_r && !out_free)) begin
              if (due) begin
                // previous due word goes out, this one is held back
                push              = held_v_r;
                wr.en             = 1'b1;
                wr.entry.last_time = now_r;
                held_nxt          = '{slot: RES_SLOT_W'(idx_r), id: ent.id,
                                      mode: ent.mode, status: ST_DUE};
                held_v_nxt        = 1'b1;
              end
              if (is_end) begin
                state_nxt = S_FLUSH;
                if (!held_v_r && !due) begin
                  held_nxt = '{slot: '0, id: '0, mode: '0, status: ST_NONE};
                end
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end
          OP_ADD: begin
            if (!ent.enabled) begin
              wr.en     = 1'b1;
              wr.entry  = '{enabled: 1'b1, mode: mode_r, id: id_r,
                            period: period_r, last_time: 64'd0};
              held_nxt  = '{slot: RES_SLOT_W'(idx_r), id: '0, mode: '0, status: ST_ADDED};
              state_nxt = S_FLUSH;
            end else if (is_end) begin
              held_nxt  = '{slot: '0, id: '0, mode: '0, status: ST_FULL};
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (match) begin
              wr.en            = 1'b1;
              wr.entry.enabled = 1'b0;
              held_nxt  = '{slot: RES_SLOT_W'(idx_r), id: '0, mode: '0, status: ST_REMOVED};
              state_nxt = S_FLUSH;
            end else if (is_end) begin
              held_nxt  = '{slot: '0, id: '0, mode: '0, status: ST_NOTFOUND};
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FLUSH: begin
        // final word carries tlast
        if (out_free) begin
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_v_r <= held_v_nxt;
      if (push || push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    held_r <= held_nxt;
    if (in_acc) begin
      op_r     <= in_tuser;
      now_r    <= in_tdata[63:0];
      mode_r   <= in_tdata[71:64];
      id_r     <= in_tdata[79:72];
      period_r <= in_tdata[111:80];
    end
    if (push || push_last) begin
      out_res_r  <= push_last ? held_r : res_mid;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};
  assign out_tlast  = out_last_r;

  // a valid op keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == OP_POLL || in_tuser == OP_ADD || in_tuser == OP_REMOVE)
    |=> !in_tready)
    else $error("block ready right after taking an item");

  // table is written only during the scan
  assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> state_r == S_SCAN)
    else $error("table write outside scan");

  // add or remove writes at most one slot and then finishes
  assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && (op_r == OP_ADD || op_r == OP_REMOVE) |=> state_r == S_FLUSH)
    else $error("add/remove kept scanning after a write");

  // flush ends in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |=> state_r == S_FLUSH || state_r == S_IDLE)
    else $error("flush left to a bad state");

  // a mid-scan push needs a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free && held_v_r)
    else $error("due word pushed over a busy output");

endmodule

/* hdl/ppts_table.sv */
// Slot table: SLOTS entries of enable, mode, id, interval and last issue time.
// One read index, one write port; reset loads the preset entries. Uses ppts_pkg.
module ppts_table import ppts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  idx_t    rd_idx,
  output slot_t   rd_entry,
  input  tbl_wr_t wr
);

  slot_t tbl_r [SLOTS];

  // storage, preset on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_r[i] <= preset_entry(i);
      end
    end else if (wr.en) begin
      tbl_r[wr.idx] <= wr.entry;
    end
  end

  assign rd_entry = tbl_r[rd_idx];

endmodule

/* test/tb_periodic_poll_table_scheduler.sv */
// Self-checking testbench for periodic_poll_table_scheduler: drives poll, add and remove
// words and checks every result word against a private copy of the slot table.
// Depends on ppts_pkg and the RTL under hdl/.

// One expected result word
typedef struct packed {
  ppts_pkg::status_t status;
  logic [7:0]        mode;
  logic [7:0]        id;
  logic [3:0]        slot;
  logic              last;
} sched_word_t;

// Slot table tracker: predicts result words and compares them as they arrive
class sched_table_scoreboard;
  localparam int MAX_DUE = 16;

  logic [7:0]  mode_q   [ppts_pkg::SLOTS];
  logic [7:0]  id_q     [ppts_pkg::SLOTS];
  logic [31:0] period_q [ppts_pkg::SLOTS];
  logic [63:0] last_q   [ppts_pkg::SLOTS];
  bit          enabled_q[ppts_pkg::SLOTS];

  sched_word_t expected_words[$];
  int          mismatches;

  function new();
    logic [7:0]  boot_id    [8] = '{8'h0C, 8'h0D, 8'h11, 8'h04, 8'h05, 8'h0F, 8'h2F, 8'h46};
    logic [31:0] boot_period[8] = '{32'd100000, 32'd100000, 32'd100000, 32'd500000,
                                    32'd1000000, 32'd1000000, 32'd5000000, 32'd5000000};
    mismatches = 0;
    // eight preset entries, the rest empty and disabled
    for (int i = 0; i < ppts_pkg::SLOTS; i++) begin
      enabled_q[i] = (i < 8);
      mode_q[i]    = (i < 8) ? 8'h01 : 8'h00;
      id_q[i]      = (i < 8) ? boot_id[i] : 8'h00;
      period_q[i]  = (i < 8) ? boot_period[i] : 32'd0;
      last_q[i]    = 64'd0;
    end
  endfunction

  function void push_word(ppts_pkg::status_t st, logic [7:0] mode, logic [7:0] id,
                          logic [3:0] slot);
    sched_word_t w;
    w.status = st;
    w.mode   = mode;
    w.id     = id;
    w.slot   = slot;
    w.last   = 1'b0;
    expected_words.push_back(w);
  endfunction

  // Update the table for one accepted input word and queue its results
  function void note_request(logic [1:0] op, logic [63:0] now, logic [7:0] mode,
                             logic [7:0] id, logic [31:0] period);
    int n;
    int hit;
    n   = 0;
    hit = -1;
    case (op)
      ppts_pkg::OP_POLL: begin
        // wrapping difference, at most MAX_DUE reports per poll
        for (int i = 0; i < ppts_pkg::SLOTS && n < MAX_DUE; i++) begin
          if (enabled_q[i] && (now - last_q[i]) >= {32'd0, period_q[i]}) begin
            push_word(ppts_pkg::ST_DUE, mode_q[i], id_q[i], 4'(i));
            last_q[i] = now;
            n++;
          end
        end
        if (n == 0) push_word(ppts_pkg::ST_NONE, 8'h00, 8'h00, 4'd0);
      end
      ppts_pkg::OP_ADD: begin
        for (int i = ppts_pkg::SLOTS - 1; i >= 0; i--)
          if (!enabled_q[i]) hit = i;
        if (hit >= 0) begin
          mode_q[hit]    = mode;
          id_q[hit]      = id;
          period_q[hit]  = period;
          last_q[hit]    = 64'd0;
          enabled_q[hit] = 1'b1;
          push_word(ppts_pkg::ST_ADDED, 8'h00, 8'h00, 4'(hit));
        end else begin
          push_word(ppts_pkg::ST_FULL, 8'h00, 8'h00, 4'd0);
        end
      end
      ppts_pkg::OP_REMOVE: begin
        for (int i = ppts_pkg::SLOTS - 1; i >= 0; i--)
          if (enabled_q[i] && mode_q[i] == mode && id_q[i] == id) hit = i;
        if (hit >= 0) begin
          enabled_q[hit] = 1'b0;
          push_word(ppts_pkg::ST_REMOVED, 8'h00, 8'h00, 4'(hit));
        end else begin
          push_word(ppts_pkg::ST_NOTFOUND, 8'h00, 8'h00, 4'd0);
        end
      end
      default: return;  // unused op: dropped, no word
    endcase
    expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  // Compare one accepted output word with the oldest expectation
  function void check_result(logic [ppts_pkg::OUT_DATA_W-1:0] data, logic tlast);
    ppts_pkg::res_t got;
    sched_word_t    exp_w;
    got = data[22:0];
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: status %0d mode %h id %h slot %0d last %b",
                 got.status, got.mode, got.id, got.slot, tlast);
      return;
    end
    exp_w = expected_words.pop_front();
    if (got.status !== exp_w.status || got.mode !== exp_w.mode || got.id !== exp_w.id ||
        got.slot !== exp_w.slot || tlast !== exp_w.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"word mismatch: exp status %0d mode %h id %h slot %0d last %b,",
                  " got %0d %h %h %0d %b"},
                 exp_w.status, exp_w.mode, exp_w.id, exp_w.slot, exp_w.last,
                 got.status, got.mode, got.id, got.slot, tlast);
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb_periodic_poll_table_scheduler import ppts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         PHASE_WORDS    = 24;
  localparam int         SEND_IDLE[4]   = '{0, 63, 0, 30};
  localparam int         RECV_STALL[4]  = '{0, 0, 63, 30};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  sched_table_scoreboard sb;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    quiet_cycles = 0;
  logic [63:0]           clock_us;

  periodic_poll_table_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one word and hold it until accepted; valid stays high on return
  task automatic send_word(logic [1:0] op, logic [63:0] now, logic [7:0] mode,
                           logic [7:0] id, logic [31:0] period);
    in_tuser  = op;
    in_tdata  = {period, id, mode, now};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, now, mode, id, period);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
  endtask

  // hold off the sender until every expected word has come back
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int         pick;
    int         r;
    int         k;
    int         hits[$];
    logic [7:0] mode_v;
    logic [7:0] id_v;
    logic [31:0] period_v;

    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_POLL;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: nothing due, first due batch, time extremes and time going back
    send_word(OP_POLL, 64'd0, 8'h00, 8'h00, 32'd0);
    send_word(OP_POLL, 64'd100000, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00, 32'd0);
    send_word(OP_POLL, 64'd1000000, 8'h00, 8'h00, 32'd0);
    send_word(OP_POLL, 64'd200, 8'h00, 8'h00, 32'd0);
    // zero interval and duplicate add, then removes down to not found
    send_word(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 32'd0);
    send_word(OP_ADD, 64'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_POLL, 64'd300, 8'h00, 8'h00, 32'd0);
    send_word(OP_REMOVE, 64'd0, 8'hFF, 8'hFF, 32'd0);
    send_word(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_REMOVE, 64'd0, 8'hFF, 8'hFF, 32'd0);
    send_word(OP_REMOVE, 64'd0, 8'h01, 8'h0C, 32'd0);
    send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    // fill the table, overflow it, then a poll with every slot due
    for (k = 0; k < 9; k++)
      send_word(OP_ADD, {$urandom, $urandom}, 8'h10 + 8'(k), 8'hA0 + 8'(k),
                (k == 8) ? 32'hFFFF_FFFF : 32'(k) * 32'd1000);
    send_word(OP_ADD, 64'd0, 8'h55, 8'h55, 32'd7);
    send_word(OP_POLL, 64'h0000_0001_0000_0000, 8'h00, 8'h00, 32'd0);
    clock_us = 64'h0000_0001_0000_0000;
    drain();

    // random phases with different idle and stall pressure
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = RECV_STALL[ph];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sender_gap();
        pick     = $urandom_range(99);
        mode_v   = 8'($urandom_range(255));
        id_v     = 8'($urandom_range(255));
        period_v = $urandom;
        if (pick < 50) begin
          // poll: mostly moving forward, sometimes back or a wild jump
          r = $urandom_range(99);
          if (r < 80) clock_us = clock_us + 64'($urandom_range(1200000));
          else if (r < 90) clock_us = clock_us - 64'($urandom_range(300000));
          else clock_us = {$urandom, $urandom};
          send_word(OP_POLL, clock_us, mode_v, id_v, period_v);
        end else if (pick < 72) begin
          r = $urandom_range(99);
          if (r < 70) period_v = 32'($urandom_range(2000000));
          else if (r < 85) period_v = 32'd0;
          if ($urandom_range(1) == 1) begin
            mode_v = 8'($urandom_range(1, 2));
            id_v   = 8'($urandom_range(15));
          end
          send_word(OP_ADD, {$urandom, $urandom}, mode_v, id_v, period_v);
        end else if (pick < 95) begin
          // remove: mostly a live entry, else whatever the random bytes give
          hits.delete();
          for (int i = 0; i < SLOTS; i++)
            if (sb.enabled_q[i]) hits.push_back(i);
          if (hits.size() != 0 && $urandom_range(99) < 80) begin
            k      = hits[$urandom_range(hits.size() - 1)];
            mode_v = sb.mode_q[k];
            id_v   = sb.id_q[k];
          end
          send_word(OP_REMOVE, {$urandom, $urandom}, mode_v, id_v, period_v);
        end else begin
          send_word(OP_UNUSED, {$urandom, $urandom}, mode_v, id_v, period_v);
        end
      end
      drain();
    end

    // let any dropped word finish and catch stray output
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
